/* rtl/aafv_pkg.sv */
// ----------------------------------------------------------------------------
// aafv_pkg: shared types and constants
// Word layouts, case codes and the CORDIC arctangent table for the
// axis/angle block.
// ----------------------------------------------------------------------------
package aafv_pkg;

  localparam int CW      = 16;          // component width, Q2.14
  localparam int FRAC    = CW - 2;      // fraction bits of a component
  localparam int ANGLE_W = 15;          // Q3.13 angle
  localparam int LIMIT_W = 29;          // Q1.28 magnitude

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd268435187;
  localparam logic [ANGLE_W-1:0] PI_Q13      = 15'd25736;
  localparam logic [31:0]        PI_Q30      = 32'd3373259426;

  localparam logic [1:0] KIND_GENERAL  = 2'd0;
  localparam logic [1:0] KIND_OPPOSITE = 2'd1;
  localparam logic [1:0] KIND_PARALLEL = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
  } vec_pair_t;

  typedef struct packed {
    logic signed [CW-1:0] axis_x;
    logic signed [CW-1:0] axis_y;
    logic signed [CW-1:0] axis_z;
    logic [ANGLE_W-1:0]   rotation_angle;
    logic [1:0]           case_kind;
  } axis_angle_t;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h3243F6A8;
      5'd1:  val = 32'h1DAC6705;
      5'd2:  val = 32'h0FADBAFC;
      5'd3:  val = 32'h07F56EA6;
      5'd4:  val = 32'h03FEAB76;
      5'd5:  val = 32'h01FFD55B;
      5'd6:  val = 32'h00FFFAAA;
      5'd7:  val = 32'h007FFF55;
      5'd8:  val = 32'h003FFFEA;
      5'd9:  val = 32'h001FFFFD;
      5'd10: val = 32'h000FFFFF;
      5'd11: val = 32'h0007FFFF;
      5'd12: val = 32'h0003FFFF;
      5'd13: val = 32'h0001FFFF;
      5'd14: val = 32'h0000FFFF;
      5'd15: val = 32'h00007FFF;
      5'd16: val = 32'h00003FFF;
      5'd17: val = 32'h00001FFF;
      5'd18: val = 32'h00000FFF;
      5'd19: val = 32'h000007FF;
      5'd20: val = 32'h000003FF;
      5'd21: val = 32'h000001FF;
      5'd22: val = 32'h000000FF;
      5'd23: val = 32'h0000007F;
      5'd24: val = 32'h0000003F;
      5'd25: val = 32'h0000001F;
      5'd26: val = 32'h0000000F;
      5'd27: val = 32'h00000008;
      5'd28: val = 32'h00000004;
      5'd29: val = 32'h00000002;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

/* rtl/aafv_isqrt.sv */
// ----------------------------------------------------------------------------
// aafv_isqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage; floor result.
// A sideband word rides along with each item.
// ----------------------------------------------------------------------------
module aafv_isqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  logic            vld    [RW+1];
  logic [2*RW-1:0] rad_s  [RW+1];
  logic [RW+1:0]   rem_s  [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [SW-1:0]   side_s [RW+1];

  assign vld[0]    = in_valid;
  assign rad_s[0]  = radicand;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] acc;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign acc   = {rem_s[k], rad_s[k][2*RW-1 -: 2]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign ge    = (acc >= trial);
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rad_s[k+1]  <= rad_s[k] << 2;
      rem_s[k+1]  <= ge ? diff[RW+1:0] : acc[RW+1:0];
      root_s[k+1] <= {root_s[k][RW-2:0], ge};
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = vld[RW];
  assign root      = root_s[RW];
  assign out_side  = side_s[RW];

endmodule

/* rtl/aafv_div.sv */
// ----------------------------------------------------------------------------
// aafv_div: pipelined multi-lane divider
// Restoring division of several numerators by one shared divisor, one
// quotient bit per stage. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module aafv_div #(
  parameter int LANES = 3,
  parameter int NW    = 46,
  parameter int DW    = 32,
  parameter int QW    = 15,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [LANES-1:0][NW-1:0]  num,
  input  logic [DW-1:0]             den,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [LANES-1:0][QW-1:0]  quo,
  output logic [SW-1:0]             out_side
);

  logic                     vld   [QW+1];
  logic [LANES-1:0][NW-1:0] rem_s [QW+1];
  logic [LANES-1:0][QW-1:0] quo_s [QW+1];
  logic [DW-1:0]            den_s [QW+1];
  logic [SW-1:0]            side_s[QW+1];

  assign vld[0]    = in_valid;
  assign rem_s[0]  = num;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] dsh;

    assign dsh = NW'(den_s[k]) << (QW - 1 - k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_s[k][l] >= dsh) begin
          rem_s[k+1][l] <= rem_s[k][l] - dsh;
          quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], 1'b1};
        end else begin
          rem_s[k+1][l] <= rem_s[k][l];
          quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], 1'b0};
        end
      end
      den_s[k+1]  <= den_s[k];
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = quo_s[QW];
  assign out_side  = side_s[QW];

endmodule

/* rtl/aafv_acos.sv */
// ----------------------------------------------------------------------------
// aafv_acos: pipelined CORDIC arccosine
// Vectoring CORDIC on (|d|, sqrt(1-d^2)), one rotation per stage, then a
// mirror for negative d and rounding to Q3.13.
// ----------------------------------------------------------------------------
module aafv_acos #(
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [28:0]             x_in,
  input  logic [28:0]             y_in,
  input  logic                    neg_in,
  output logic                    out_valid,
  output logic [aafv_pkg::ANGLE_W-1:0] angle
);

  import aafv_pkg::*;

  localparam int XW = 33;
  localparam int ZW = 34;

  logic                 vld   [STAGES+1];
  logic signed [XW-1:0] x_s   [STAGES+1];
  logic signed [XW-1:0] y_s   [STAGES+1];
  logic signed [ZW-1:0] z_s   [STAGES+1];
  logic                 neg_s [STAGES+1];

  assign vld[0]   = in_valid;
  assign x_s[0]   = signed'(XW'(x_in));
  assign y_s[0]   = signed'(XW'(y_in));
  assign z_s[0]   = '0;
  assign neg_s[0] = neg_in;

  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;

    assign dx = y_s[k] >>> k;
    assign dy = x_s[k] >>> k;
    assign at = signed'({2'b00, atan_q30(5'(k))});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!y_s[k][XW-1]) begin
        x_s[k+1] <= x_s[k] + dx;
        y_s[k+1] <= y_s[k] - dy;
        z_s[k+1] <= z_s[k] + at;
      end else begin
        x_s[k+1] <= x_s[k] - dx;
        y_s[k+1] <= y_s[k] + dy;
        z_s[k+1] <= z_s[k] - at;
      end
      neg_s[k+1] <= neg_s[k];
    end
  end

  // mirror and clamp to 0..pi
  logic signed [ZW-1:0] pi_s;
  logic signed [ZW-1:0] zm;
  logic [31:0]          zc_next;
  logic [31:0]          zc;
  logic                 zc_vld;

  assign pi_s = signed'({2'b00, PI_Q30});
  assign zm   = neg_s[STAGES] ? (pi_s - z_s[STAGES]) : z_s[STAGES];

  always_comb begin
    if (zm[ZW-1]) begin
      zc_next = '0;
    end else if (zm > pi_s) begin
      zc_next = PI_Q30;
    end else begin
      zc_next = zm[31:0];
    end
  end

  // round Q.30 to Q.13
  logic [32:0] zr;
  logic [15:0] zq;

  assign zr = {1'b0, zc} + 33'd65536;
  assign zq = zr[32:17];

  always_ff @(posedge clk) begin
    if (rst) begin
      zc_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      zc_vld    <= vld[STAGES];
      out_valid <= zc_vld;
    end
  end

  always_ff @(posedge clk) begin
    zc    <= zc_next;
    angle <= (zq > 16'(PI_Q13)) ? PI_Q13 : zq[ANGLE_W-1:0];
  end

endmodule

/* rtl/aafv_delay.sv */
// ----------------------------------------------------------------------------
// aafv_delay: valid-tagged delay line
// Balances the axis and angle paths to the same latency.
// ----------------------------------------------------------------------------
module aafv_delay #(
  parameter int LEN = 1,
  parameter int W   = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  if (LEN == 0) begin : g_none
    assign out_valid = in_valid;
    assign out_data  = in_data;
  end else begin : g_line
    logic         vld [LEN];
    logic [W-1:0] dat [LEN];

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int i = 0; i < LEN; i++) begin
          vld[i] <= 1'b0;
        end
      end else begin
        vld[0] <= in_valid;
        for (int i = 1; i < LEN; i++) begin
          vld[i] <= vld[i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      dat[0] <= in_data;
      for (int i = 1; i < LEN; i++) begin
        dat[i] <= dat[i-1];
      end
    end

    assign out_valid = vld[LEN-1];
    assign out_data  = dat[LEN-1];
  end

endmodule

/* rtl/axis_angle_from_two_vectors.sv */
// ----------------------------------------------------------------------------
// axis_angle_from_two_vectors: rotation axis and angle between two vectors
//
// Input word: vectors (two Q2.14 3-vectors), taken at a clock edge where
// start is high and busy is low. busy is always low: the pipeline takes a
// new word every cycle.
// Output word: result (unit Q2.14 axis, Q3.13 angle, case code), on the
// result port for one cycle with done high. There is no back-pressure.
// Two parallel paths lead to the output register: the axis path (32-stage
// square root plus 15-stage divider) and the angle path (29-stage square
// root plus CORDIC_STAGES rotations). The angle path is the longer one only
// for CORDIC_STAGES above 20; the shorter path is padded by a delay line.
// Throughput: one word per cycle.
// Config: limit_we/limit_data write the parallel limit (Q1.28), reset to
// 0.999999. Write it only while no word is in flight.
// Reset: synchronous; clears all valid bits and reloads the limit.
// ----------------------------------------------------------------------------
module axis_angle_from_two_vectors #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  aafv_pkg::vec_pair_t            vectors,
  input  logic                           limit_we,
  input  logic [aafv_pkg::LIMIT_W-1:0]   limit_data,
  output logic                           done,
  output aafv_pkg::axis_angle_t          result
);

  import aafv_pkg::*;

  localparam int PW     = 2 * CW;       // raw product width
  localparam int CRW    = 2 * CW + 1;   // cross / axis component width
  localparam int MAGW   = 2 * CW - 1;   // axis magnitude width
  localparam int DOTW   = 30;           // saturated dot, +-2^28
  localparam int SQR_RW = 32;           // axis norm root width
  localparam int ANG_RW = 29;           // sqrt(1-d^2) root width
  localparam int QW     = FRAC + 1;     // quotient width
  localparam int NW     = MAGW + FRAC + 1;
  localparam int AX_LAT  = 3 + SQR_RW + 1 + QW;
  localparam int ANG_LAT = ANG_RW + CORDIC_STAGES + 2;
  localparam int AX_DLY  = (ANG_LAT > AX_LAT) ? ANG_LAT - AX_LAT : 0;
  localparam int ANG_DLY = (AX_LAT > ANG_LAT) ? AX_LAT - ANG_LAT : 0;

  // never holds off: one word per cycle
  assign busy = 1'b0;

  // limit register
  logic [LIMIT_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (limit_we) begin
      limit <= limit_data;
    end
  end

  // --------------------------------------------------------------------------
  // s1: all nine component products
  // --------------------------------------------------------------------------
  logic                 s1_vld;
  logic signed [CW-1:0] s1_a [3];
  logic signed [PW-1:0] s1_pd [3];  // dot terms
  logic signed [PW-1:0] s1_pc [6];  // cross terms: yz zy zx xz xy yx

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_a[0]  <= vectors.first_x;
    s1_a[1]  <= vectors.first_y;
    s1_a[2]  <= vectors.first_z;
    s1_pd[0] <= vectors.first_x * vectors.second_x;
    s1_pd[1] <= vectors.first_y * vectors.second_y;
    s1_pd[2] <= vectors.first_z * vectors.second_z;
    s1_pc[0] <= vectors.first_y * vectors.second_z;
    s1_pc[1] <= vectors.first_z * vectors.second_y;
    s1_pc[2] <= vectors.first_z * vectors.second_x;
    s1_pc[3] <= vectors.first_x * vectors.second_z;
    s1_pc[4] <= vectors.first_x * vectors.second_y;
    s1_pc[5] <= vectors.first_y * vectors.second_x;
  end

  // --------------------------------------------------------------------------
  // s2: saturated dot, cross product, opposite-case axis candidate
  // --------------------------------------------------------------------------
  logic signed [PW+1:0]  dsum;
  logic signed [DOTW-1:0] dot_next;
  logic signed [CRW-1:0] opp_next [3];

  assign dsum = (PW+2)'(s1_pd[0]) + (PW+2)'(s1_pd[1]) + (PW+2)'(s1_pd[2]);

  always_comb begin
    if (dsum > 34'sd268435456) begin
      dot_next = 30'sd268435456;
    end else if (dsum < -34'sd268435456) begin
      dot_next = -30'sd268435456;
    end else begin
      dot_next = DOTW'(dsum);
    end
  end

  // x-unit cross v1, or y-unit cross v1 when that is zero
  always_comb begin
    if (s1_a[1] != '0 || s1_a[2] != '0) begin
      opp_next[0] = '0;
      opp_next[1] = -(CRW'(s1_a[2]) <<< FRAC);
      opp_next[2] = CRW'(s1_a[1]) <<< FRAC;
    end else begin
      opp_next[0] = '0;
      opp_next[1] = '0;
      opp_next[2] = -(CRW'(s1_a[0]) <<< FRAC);
    end
  end

  logic                   s2_vld;
  logic signed [DOTW-1:0] s2_dot;
  logic signed [CRW-1:0]  s2_crs [3];
  logic signed [CRW-1:0]  s2_opp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_dot    <= dot_next;
    s2_crs[0] <= CRW'(s1_pc[0]) - CRW'(s1_pc[1]);
    s2_crs[1] <= CRW'(s1_pc[2]) - CRW'(s1_pc[3]);
    s2_crs[2] <= CRW'(s1_pc[4]) - CRW'(s1_pc[5]);
    for (int i = 0; i < 3; i++) begin
      s2_opp[i] <= opp_next[i];
    end
  end

  // --------------------------------------------------------------------------
  // s3: classify, pick the raw axis, magnitudes; d^2 for the angle
  // --------------------------------------------------------------------------
  logic signed [DOTW:0]   lim_s;
  logic signed [DOTW:0]   dot_w;
  logic                   is_opp;
  logic                   is_par;
  logic [1:0]             kind_next;
  logic signed [CRW-1:0]  sel [3];
  logic signed [CRW-1:0]  absv [3];
  logic signed [2*DOTW-1:0] dsq_full;
  logic signed [DOTW-1:0] dabs;

  assign lim_s  = signed'({2'b00, limit});
  assign dot_w  = (DOTW+1)'(s2_dot);
  assign is_opp = (dot_w < -lim_s);
  assign is_par = (dot_w > lim_s);
  assign dsq_full = s2_dot * s2_dot;
  assign dabs   = s2_dot[DOTW-1] ? -s2_dot : s2_dot;

  always_comb begin
    if (is_opp) begin
      kind_next = KIND_OPPOSITE;
    end else if (is_par) begin
      kind_next = KIND_PARALLEL;
    end else begin
      kind_next = KIND_GENERAL;
    end
    for (int i = 0; i < 3; i++) begin
      if (is_opp) begin
        sel[i] = s2_opp[i];
      end else if (is_par) begin
        sel[i] = '0;
      end else begin
        sel[i] = s2_crs[i];
      end
      absv[i] = sel[i][CRW-1] ? -sel[i] : sel[i];
    end
  end

  logic             s3_vld;
  logic [MAGW-1:0]  s3_mag [3];
  logic [2:0]       s3_neg;
  logic [1:0]       s3_kind;
  logic [56:0]      s3_dsq;
  logic [28:0]      s3_xabs;
  logic             s3_dneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_mag[i] <= absv[i][MAGW-1:0];
      s3_neg[i] <= sel[i][CRW-1];
    end
    s3_kind <= kind_next;
    s3_dsq  <= dsq_full[56:0];
    s3_xabs <= dabs[28:0];
    s3_dneg <= s2_dot[DOTW-1];
  end

  // --------------------------------------------------------------------------
  // s4: normalize shift count; 1 - d^2
  // --------------------------------------------------------------------------
  logic [MAGW-1:0] orv;
  logic [4:0]      msb;
  logic [4:0]      sh_next;

  assign orv = s3_mag[0] | s3_mag[1] | s3_mag[2];

  always_comb begin
    msb = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (orv[i]) begin
        msb = 5'(i);
      end
    end
    sh_next = 5'(MAGW - 1) - msb;
  end

  logic            s4_vld;
  logic [MAGW-1:0] s4_mag [3];
  logic [2:0]      s4_neg;
  logic [1:0]      s4_kind;
  logic            s4_zero;
  logic [4:0]      s4_sh;
  logic [56:0]     s4_v;
  logic [28:0]     s4_xabs;
  logic            s4_dneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_mag[i] <= s3_mag[i];
    end
    s4_neg  <= s3_neg;
    s4_kind <= s3_kind;
    s4_zero <= (orv == '0);
    s4_sh   <= sh_next;
    s4_v    <= {1'b1, 56'd0} - s3_dsq;
    s4_xabs <= s3_xabs;
    s4_dneg <= s3_dneg;
  end

  // --------------------------------------------------------------------------
  // angle path: sqrt(1 - d^2), CORDIC, pad
  // --------------------------------------------------------------------------
  logic              asq_vld;
  logic [ANG_RW-1:0] asq_root;
  logic [29:0]       asq_side;
  logic              acos_vld;
  logic [ANGLE_W-1:0] acos_angle;
  logic              ang_vld;
  logic [ANGLE_W-1:0] ang;

  aafv_isqrt #(.RW(ANG_RW), .SW(30)) u_ang_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s4_vld),
    .radicand ({1'b0, s4_v}),
    .in_side  ({s4_xabs, s4_dneg}),
    .out_valid(asq_vld),
    .root     (asq_root),
    .out_side (asq_side)
  );

  aafv_acos #(.STAGES(CORDIC_STAGES)) u_acos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (asq_vld),
    .x_in     (asq_side[29:1]),
    .y_in     (asq_root),
    .neg_in   (asq_side[0]),
    .out_valid(acos_vld),
    .angle    (acos_angle)
  );

  aafv_delay #(.LEN(ANG_DLY), .W(ANGLE_W)) u_ang_dly (
    .clk      (clk),
    .rst      (rst),
    .in_valid (acos_vld),
    .in_data  (acos_angle),
    .out_valid(ang_vld),
    .out_data (ang)
  );

  // --------------------------------------------------------------------------
  // axis path: s5 shift, s6 squares, s7 sum, root, s8 numerators, divide
  // --------------------------------------------------------------------------
  logic            s5_vld;
  logic [MAGW-1:0] s5_mag [3];
  logic [2:0]      s5_neg;
  logic [1:0]      s5_kind;
  logic            s5_zero;

  logic              s6_vld;
  logic [2*MAGW-1:0] s6_sq [3];
  logic [MAGW-1:0]   s6_mag [3];
  logic [2:0]        s6_neg;
  logic [1:0]        s6_kind;
  logic              s6_zero;

  logic            s7_vld;
  logic [63:0]     s7_sum;
  logic [MAGW-1:0] s7_mag [3];
  logic [2:0]      s7_neg;
  logic [1:0]      s7_kind;
  logic            s7_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_mag[i] <= s4_mag[i] << s4_sh;
      s6_sq[i]  <= (2*MAGW)'(s5_mag[i]) * (2*MAGW)'(s5_mag[i]);
      s6_mag[i] <= s5_mag[i];
      s7_mag[i] <= s6_mag[i];
    end
    s5_neg  <= s4_neg;
    s5_kind <= s4_kind;
    s5_zero <= s4_zero;
    s6_neg  <= s5_neg;
    s6_kind <= s5_kind;
    s6_zero <= s5_zero;
    s7_sum  <= 64'(s6_sq[0]) + 64'(s6_sq[1]) + 64'(s6_sq[2]);
    s7_neg  <= s6_neg;
    s7_kind <= s6_kind;
    s7_zero <= s6_zero;
  end

  localparam int XSW = 3 * MAGW + 6;

  logic              nsq_vld;
  logic [SQR_RW-1:0] nsq_root;
  logic [XSW-1:0]    nsq_side;

  aafv_isqrt #(.RW(SQR_RW), .SW(XSW)) u_norm_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s7_vld),
    .radicand (s7_sum),
    .in_side  ({s7_mag[2], s7_mag[1], s7_mag[0], s7_neg, s7_kind, s7_zero}),
    .out_valid(nsq_vld),
    .root     (nsq_root),
    .out_side (nsq_side)
  );

  // q = (mag * unit + n/2) / n
  logic                  s8_vld;
  logic [2:0][NW-1:0]    s8_num;
  logic [SQR_RW-1:0]     s8_den;
  logic [5:0]            s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= nsq_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s8_num[i] <= (NW'(nsq_side[6 + i*MAGW +: MAGW]) << FRAC) + NW'(nsq_root >> 1);
    end
    s8_den  <= nsq_root;
    s8_side <= nsq_side[5:0];
  end

  logic               div_vld;
  logic [2:0][QW-1:0] div_quo;
  logic [5:0]         div_side;

  aafv_div #(.LANES(3), .NW(NW), .DW(SQR_RW), .QW(QW), .SW(6)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s8_vld),
    .num      (s8_num),
    .den      (s8_den),
    .in_side  (s8_side),
    .out_valid(div_vld),
    .quo      (div_quo),
    .out_side (div_side)
  );

  localparam int AXDW = 3 * QW + 6;

  logic            ax_vld;
  logic [AXDW-1:0] ax_dat;

  aafv_delay #(.LEN(AX_DLY), .W(AXDW)) u_ax_dly (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_vld),
    .in_data  ({div_quo, div_side}),
    .out_valid(ax_vld),
    .out_data (ax_dat)
  );

  // --------------------------------------------------------------------------
  // output register: signs, zero axis, per-case angle
  // --------------------------------------------------------------------------
  logic [2:0]           o_neg;
  logic [1:0]           o_kind;
  logic                 o_zero;
  logic signed [CW-1:0] o_ax [3];
  logic [ANGLE_W-1:0]   o_ang;
  axis_angle_t          result_next;

  assign o_neg  = ax_dat[5:3];
  assign o_kind = ax_dat[2:1];
  assign o_zero = ax_dat[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (o_zero) begin
        o_ax[i] = '0;
      end else if (o_neg[i]) begin
        o_ax[i] = -signed'(CW'(ax_dat[6 + i*QW +: QW]));
      end else begin
        o_ax[i] = signed'(CW'(ax_dat[6 + i*QW +: QW]));
      end
    end
    case (o_kind)
      KIND_OPPOSITE: o_ang = PI_Q13;
      KIND_PARALLEL: o_ang = '0;
      default:       o_ang = ang;
    endcase
    result_next.axis_x         = o_ax[0];
    result_next.axis_y         = o_ax[1];
    result_next.axis_z         = o_ax[2];
    result_next.rotation_angle = o_ang;
    result_next.case_kind      = o_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ax_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    ax_vld == ang_vld)
    else $error("axis and angle paths out of step");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> s1_vld)
    else $error("accepted word did not enter the pipeline");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.case_kind == KIND_GENERAL || result.case_kind == KIND_OPPOSITE
              || result.case_kind == KIND_PARALLEL))
    else $error("bad case code");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.case_kind == KIND_PARALLEL) |->
      (result.axis_x == '0 && result.axis_y == '0 && result.axis_z == '0
       && result.rotation_angle == '0))
    else $error("parallel case must give zero axis and angle");

  a_opposite_pi: assert property (@(posedge clk) disable iff (rst)
    (done && result.case_kind == KIND_OPPOSITE) |-> result.rotation_angle == PI_Q13)
    else $error("opposite case must give angle pi");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.rotation_angle <= PI_Q13)
    else $error("angle above pi");

endmodule
